### rtl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// Holds the register codes, the fixed field widths and the cell interface structs.
// No dependencies.
package wbps_pkg;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned PAT_W      = 128;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW   = 2'd0,
    REG_PAT_HIGH  = 2'd1,
    REG_WILD_MASK = 2'd2,
    REG_PAT_LEN   = 2'd3
  } cfg_reg_t;

  // Per-cycle control shared by every cell of the window.
  typedef struct packed {
    logic shift;   // a word is taken this cycle
    logic drain;   // that word ends the scan, so the window empties after it
  } cell_ctrl_t;

  // What one cell compares its incoming byte against.
  typedef struct packed {
    logic [7:0] exp_byte;
    logic       wild;
    logic       active;  // the cell lies inside the pattern length
  } cell_cfg_t;

endpackage

### rtl/wildcard_byte_pattern_scanner_unit.sv
// Wildcard byte pattern scanner: one word (a byte and its address) is taken per cycle.
// A result is registered and appears on the output in the cycle after the word that causes it.
// Throughput: one word per cycle, set by the row of window cells that shift and compare
// every position in the same cycle; input stalls only while an unread result is held.
// Reset (synchronous, rst_n low): window emptied, scan state cleared, pattern registers
// to zero except the pattern length, which returns to one.
module wildcard_byte_pattern_scanner_unit #(
  parameter int unsigned WINDOW_CELLS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input words.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  input  logic [wbps_pkg::ADDR_W-1:0]        in_byte_address,
  input  logic                               in_region_start,
  input  logic                               in_scan_end,
  // Result words.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [wbps_pkg::ADDR_W-1:0]        out_match_address,
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wbps_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(WINDOW_CELLS);

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never pushes back.
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] pat_low_r,  pat_low_nxt;
  logic [CFG_DATA_W-1:0] pat_high_r, pat_high_nxt;
  logic [MASK_W-1:0]     wild_r,     wild_nxt;
  logic [LEN_W-1:0]      len_r,      len_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    pat_low_nxt  = pat_low_r;
    pat_high_nxt = pat_high_r;
    wild_nxt     = wild_r;
    len_nxt      = len_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAT_LOW:   pat_low_nxt  = cfg_data;
        REG_PAT_HIGH:  pat_high_nxt = cfg_data;
        REG_WILD_MASK: wild_nxt     = cfg_data[MASK_W-1:0];
        REG_PAT_LEN:   len_nxt      = cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      wild_r     <= '0;
      len_r      <= LEN_W'(1);
    end else begin
      pat_low_r  <= pat_low_nxt;
      pat_high_r <= pat_high_nxt;
      wild_r     <= wild_nxt;
      len_r      <= len_nxt;
    end
  end

  // A length of zero behaves as one, and anything above the window size is
  // clamped to the number of cells.
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] eff_len_m1;
  logic [PAT_W-1:0] pat_all;

  always_comb begin
    if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_r > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = len_r;
    end
  end

  assign eff_len_m1 = eff_len - LEN_W'(1);
  assign pat_all    = {pat_high_r, pat_low_r};

  // ---------------------------------------------------------------------------
  // Handshake. The output register parts the two sides: a new word is taken
  // whenever the result register is empty or is being read in this cycle.
  // ---------------------------------------------------------------------------
  logic       in_acc;
  logic       out_load;
  cell_ctrl_t ctrl;

  assign out_load = !out_valid || !out_stall;
  assign in_stall = !out_load;
  assign in_acc   = in_valid && out_load;

  assign ctrl.shift = in_acc;
  assign ctrl.drain = in_scan_end;

  // ---------------------------------------------------------------------------
  // Window: a row of cells, cell 0 holding the newest byte. Each cycle a word
  // is taken, every cell passes its byte to the next one. At the start of a
  // region only the new byte stays valid. Cell j compares against pattern
  // byte (length - 1 - j), so the oldest byte of a full match meets byte 0.
  // ---------------------------------------------------------------------------
  logic [7:0]              byte_q   [WINDOW_CELLS];
  logic [7:0]              byte_in  [WINDOW_CELLS];
  logic [WINDOW_CELLS-1:0] valid_q;
  logic [WINDOW_CELLS-1:0] valid_in;
  logic [WINDOW_CELLS-1:0] hit;

  for (genvar j = 0; j < WINDOW_CELLS; j++) begin : g_cell
    logic [LEN_W-1:0] pos;
    logic [3:0]       pat_idx;
    cell_cfg_t        cfg;

    assign pos          = eff_len_m1 - LEN_W'(j);
    assign pat_idx      = pos[3:0];
    assign cfg.active   = eff_len > LEN_W'(j);
    assign cfg.exp_byte = pat_all[pat_idx*8 +: 8];
    assign cfg.wild     = wild_r[pat_idx];

    if (j == 0) begin : g_head
      assign byte_in[j]  = in_data_byte;
      assign valid_in[j] = 1'b1;
    end else begin : g_body
      assign byte_in[j]  = byte_q[j-1];
      assign valid_in[j] = valid_q[j-1] && !in_region_start;
    end

    wbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .cfg      (cfg),
      .byte_in  (byte_in[j]),
      .valid_in (valid_in[j]),
      .byte_q   (byte_q[j]),
      .valid_q  (valid_q[j]),
      .hit      (hit[j])
    );
  end

  // ---------------------------------------------------------------------------
  // Scan state. Only the first match of a scan is reported; the scan end
  // reports a miss when nothing was found, and then starts a new scan.
  // ---------------------------------------------------------------------------
  logic reported_r, reported_nxt;
  logic match;
  logic end_miss;

  assign match    = !reported_r && (&hit);
  assign end_miss = in_scan_end && !reported_r && !match;

  always_comb begin
    reported_nxt = reported_r;
    if (in_acc) begin
      if (in_scan_end) begin
        reported_nxt = 1'b0;
      end else if (match) begin
        reported_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reported_r <= 1'b0;
    end else begin
      reported_r <= reported_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. The address reported is that of the oldest matched byte.
  // ---------------------------------------------------------------------------
  logic              out_valid_r, out_valid_nxt;
  logic              found_r,     found_nxt;
  logic [ADDR_W-1:0] addr_r,      addr_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    addr_nxt      = addr_r;
    if (out_load) begin
      out_valid_nxt = in_acc && (match || end_miss);
      found_nxt     = match;
      addr_nxt      = match ? (in_byte_address - ADDR_W'(eff_len_m1)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    addr_r  <= addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_match_address = addr_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // The valid cells always form an unbroken run from the newest byte.
  a_fill_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_q & (valid_q + WINDOW_CELLS'(1))) == '0)
    else $error("window valid bits are not contiguous");

  // The word that ends a scan leaves an empty window and a fresh scan state.
  a_scan_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_scan_end) |=> (valid_q == '0 && !reported_r))
    else $error("scan end did not clear the window");

  // A region start mid-scan leaves only the newest byte valid.
  a_region_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_region_start && !in_scan_end) |=> (valid_q == WINDOW_CELLS'(1)))
    else $error("region start did not flush the window");

  // A miss result always carries a zero address.
  a_miss_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_address == '0))
    else $error("miss result with a non-zero address");

endmodule

### rtl/wbps_cell.sv
// One window cell of the scanner: holds a byte and its valid flag, and compares
// the byte arriving from its neighbour or the scanner input against its pattern byte.
// Depends on wbps_pkg.
module wbps_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  wbps_pkg::cell_ctrl_t ctrl,
  input  wbps_pkg::cell_cfg_t  cfg,
  input  logic [7:0]          byte_in,
  input  logic                valid_in,
  output logic [7:0]          byte_q,
  output logic                valid_q,
  output logic                hit
);
  import wbps_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       valid_r;
  logic       valid_nxt;

  // The compare looks at the byte that enters the cell this cycle.
  assign hit = !cfg.active || (valid_in && (cfg.wild || (byte_in == cfg.exp_byte)));

  always_comb begin
    byte_nxt  = byte_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      byte_nxt  = byte_in;
      valid_nxt = valid_in && !ctrl.drain;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q  = byte_r;
  assign valid_q = valid_r;

endmodule
